// ===== hdl/mrpt_pkg.sv =====
// package for the miller-rabin prime test block
// holds widths, witness base table and the controller state type; no dependencies
package mrpt_pkg;
   localparam int W = 63;
   localparam int NUM_WITNESSES = 12;
   localparam int WIT_W = 4;
   localparam int BIT_W = 6;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SETUP, ST_SPLIT, ST_BASE, ST_EXP_BIT, ST_MUL, ST_EXP_NEXT,
      ST_CHECK, ST_SQR, ST_SQR_CHECK, ST_DONE
   } state_type;

   function automatic logic [5:0] witness_base(input logic [WIT_W-1:0] i);
      case (i)
         4'd0: return 6'd2;
         4'd1: return 6'd3;
         4'd2: return 6'd5;
         4'd3: return 6'd7;
         4'd4: return 6'd11;
         4'd5: return 6'd13;
         4'd6: return 6'd17;
         4'd7: return 6'd19;
         4'd8: return 6'd23;
         4'd9: return 6'd29;
         4'd10: return 6'd31;
         4'd11: return 6'd37;
         default: return 6'd37;
      endcase
   endfunction
endpackage

// ===== hdl/miller_rabin_prime_test.sv =====
// miller-rabin prime test, deterministic for 63-bit candidates, bases 2..37
// values below 4 and even values skip the exponentiation; otherwise each base runs 63 square
// steps, one multiply per set bit of d and up to s-1 squarings, all bit-serial modular products
// throughput: one candidate at a time; the next transfer is taken only after the result transfer
// reset: synchronous active high, returns controller to idle and drops rsp_valid
module miller_rabin_prime_test (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [mrpt_pkg::W-1:0] req_candidate,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_prime_flag
);
   import mrpt_pkg::*;

   state_type state_ff, state_in;

   // operands, all below 2^63
   logic [W-1:0] n_ff, d_ff, x_ff, b_ff;
   logic [BIT_W-1:0] s_ff, r_ff;
   logic [BIT_W:0] bit_ff;          // exponent bit index
   logic [WIT_W-1:0] wit_ff;
   logic flag_ff, rsp_valid_ff;

   // bit-serial multiplier: acc += a when b bit set, a doubles, b shifts, all reduced mod n;
   // a product ends once b is zero or all 63 bits of b are used
   logic [W-1:0] ma_ff, mb_ff, macc_ff;
   logic mul_dst_ff;                // 0: result x, 1: base b
   logic [BIT_W:0] mcnt_ff;

   logic [W:0] acc_sum, a_dbl;
   logic [W-1:0] acc_red, a_red, nm1;
   logic [5:0] base;

   assign nm1 = n_ff - 1'b1;
   assign base = witness_base(wit_ff);
   assign acc_sum = {1'b0, macc_ff} + {1'b0, ma_ff};
   assign acc_red = (acc_sum >= {1'b0, n_ff}) ? W'(acc_sum - {1'b0, n_ff}) : acc_sum[W-1:0];
   assign a_dbl = {ma_ff, 1'b0};
   assign a_red = (a_dbl >= {1'b0, n_ff}) ? W'(a_dbl - {1'b0, n_ff}) : a_dbl[W-1:0];

   // a pending result holds off the next candidate so flag_ff stays put
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_prime_flag = flag_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid && req_ready) state_in = ST_SETUP;
         ST_SETUP: begin
            if (n_ff < 63'd4 || !n_ff[0]) state_in = ST_DONE;
            else state_in = ST_SPLIT;
         end
         ST_SPLIT: if (d_ff[0]) state_in = ST_BASE;
         ST_BASE: begin
            if (wit_ff == WIT_W'(NUM_WITNESSES) || {57'd0, base} >= n_ff) state_in = ST_DONE;
            else state_in = ST_EXP_BIT;
         end
         ST_EXP_BIT: begin
            if (bit_ff == (BIT_W+1)'(W)) state_in = ST_CHECK;
            else state_in = ST_MUL;
         end
         ST_MUL: if (mcnt_ff == (BIT_W+1)'(W) || mb_ff == '0) state_in = ST_EXP_NEXT;
         ST_EXP_NEXT: state_in = ST_EXP_BIT;
         ST_CHECK: begin
            if (x_ff == 63'd1 || x_ff == nm1) state_in = ST_BASE;
            else if (r_ff >= s_ff) state_in = ST_DONE;
            else state_in = ST_SQR;
         end
         ST_SQR: if (mcnt_ff == (BIT_W+1)'(W) || mb_ff == '0) state_in = ST_SQR_CHECK;
         ST_SQR_CHECK: begin
            if (macc_ff == nm1) state_in = ST_BASE;
            else if (r_ff + 1'b1 >= s_ff) state_in = ST_DONE;
            else state_in = ST_SQR;
         end
         ST_DONE: if (!rsp_valid_ff) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         else if (state_ff == ST_DONE && !rsp_valid_ff) rsp_valid_ff <= 1'b1;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: if (req_valid && req_ready) begin
            n_ff <= req_candidate;
            flag_ff <= 1'b0;
         end
         ST_SETUP: begin
            flag_ff <= (n_ff == 63'd2 || n_ff == 63'd3);
            d_ff <= nm1;
            s_ff <= '0;
            wit_ff <= '0;
         end
         ST_SPLIT: if (!d_ff[0]) begin
            d_ff <= d_ff >> 1;
            s_ff <= s_ff + 1'b1;
         end
         ST_BASE: begin
            if (wit_ff == WIT_W'(NUM_WITNESSES) || {57'd0, base} >= n_ff) flag_ff <= 1'b1;
            x_ff <= 63'd1;
            b_ff <= {57'd0, base};
            bit_ff <= '0;
            mul_dst_ff <= 1'b0;
         end
         ST_EXP_BIT: begin
            // multiply x by b if bit set, else square b directly
            macc_ff <= '0;
            mcnt_ff <= '0;
            if (d_ff[bit_ff[BIT_W-1:0]] && !mul_dst_ff) begin
               ma_ff <= b_ff;
               mb_ff <= x_ff;
            end else begin
               ma_ff <= b_ff;
               mb_ff <= b_ff;
               mul_dst_ff <= 1'b1;
            end
         end
         ST_MUL, ST_SQR: begin
            if (mcnt_ff != (BIT_W+1)'(W) && mb_ff != '0) begin
               if (mb_ff[0]) macc_ff <= acc_red;
               ma_ff <= a_red;
               mb_ff <= mb_ff >> 1;
               mcnt_ff <= mcnt_ff + 1'b1;
            end
         end
         ST_EXP_NEXT: begin
            if (mul_dst_ff) begin
               b_ff <= macc_ff;
               mul_dst_ff <= 1'b0;
               bit_ff <= bit_ff + 1'b1;
            end else begin
               x_ff <= macc_ff;
               mul_dst_ff <= 1'b1;
            end
            r_ff <= 6'd1;
         end
         ST_CHECK: begin
            ma_ff <= x_ff;
            mb_ff <= x_ff;
            macc_ff <= '0;
            mcnt_ff <= '0;
            if (x_ff == 63'd1 || x_ff == nm1) wit_ff <= wit_ff + 1'b1;
         end
         ST_SQR_CHECK: begin
            x_ff <= macc_ff;
            ma_ff <= macc_ff;
            mb_ff <= macc_ff;
            macc_ff <= '0;
            mcnt_ff <= '0;
            r_ff <= r_ff + 1'b1;
            if (macc_ff == nm1) wit_ff <= wit_ff + 1'b1;
         end
         default: ;
      endcase
   end
endmodule

// ===== tb/sv/tb.sv =====
// testbench for miller_rabin_prime_test: drives 63-bit candidates, predicts primality
// with its own deterministic miller-rabin model; depends on mrpt_pkg and the block
module tb;
   import mrpt_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [W-1:0] req_candidate;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_prime_flag;

   // expected flags, oldest first
   bit expected_flags[$];
   int mismatch_count;
   int unexpected_count;
   int idle_cycles;
   int burst_left;

   miller_rabin_prime_test uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_candidate(req_candidate),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_prime_flag(rsp_prime_flag)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // (a*b) mod m by shift-and-add, every sum stays inside 64 bits
   function automatic logic [63:0] mulmod(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] m);
      logic [63:0] acc;
      acc = 0;
      a = a % m;
      b = b % m;
      while (b != 0) begin
         if (b[0]) begin
            acc = acc + a;
            if (acc >= m) acc = acc - m;
         end
         a = a + a;
         if (a >= m) a = a - m;
         b = b >> 1;
      end
      return acc;
   endfunction

   function automatic logic [63:0] powmod(input logic [63:0] b, input logic [63:0] e,
                                          input logic [63:0] m);
      logic [63:0] r;
      r = 1 % m;
      b = b % m;
      while (e != 0) begin
         if (e[0]) r = mulmod(r, b, m);
         b = mulmod(b, b, m);
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic bit predict_prime(input logic [W-1:0] cand);
      logic [63:0] n;
      logic [63:0] d;
      logic [63:0] x;
      int s;
      bit passed;
      int unsigned bases[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
      n = {1'b0, cand};
      if (n < 2) return 0;
      if (n == 2 || n == 3) return 1;
      if (!n[0]) return 0;
      d = n - 1;
      s = 0;
      while (!d[0]) begin
         d = d >> 1;
         s++;
      end
      for (int i = 0; i < NUM_WITNESSES && i < 12; i++) begin
         // a base not below n ends the test as prime
         if (64'(bases[i]) >= n) break;
         x = powmod(64'(bases[i]), d, n);
         if (x == 1 || x == n - 1) continue;
         passed = 0;
         for (int r = 1; r < s; r++) begin
            x = mulmod(x, x, n);
            if (x == n - 1) begin
               passed = 1;
               break;
            end
         end
         if (!passed) return 0;
      end
      return 1;
   endfunction

   // send one candidate; sender works in random bursts with gaps between them
   task automatic send_candidate(input logic [W-1:0] cand);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 6);
         gap = $urandom_range(0, 3);
         // gap with valid low
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_candidate <= cand;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // transfer happened at this edge
      expected_flags.push_back(predict_prime(cand));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_flags.size() != 0) @(posedge clock);
   endtask

   // small values, both ends of the range, base boundary
   task automatic test_directed();
      logic [W-1:0] list[$] = '{63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd5, 63'd9, 63'd25,
                                63'd37, 63'd41, 63'd1369, 63'd2047, 63'd3215031751,
                                63'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFE7,
                                63'h7FFF_FFFF_FFFF_FFFE, 63'h4000_0000_0000_0000,
                                63'h4000_0000_0000_0001, 63'd3825123056546413051,
                                63'd1000000007, 63'h5555_5555_5555_5555};
      foreach (list[i]) send_candidate(list[i]);
   endtask

   // hold off until every expected result has arrived, then send two more candidates
   task automatic test_drain_pause();
      wait_drained();
      send_candidate(63'd97);
      send_candidate(63'd561);
   endtask

   task automatic test_random();
      logic [W-1:0] c;
      for (int i = 0; i < 100; i++) begin
         c = W'({$urandom, $urandom});
         case ($urandom_range(0, 3))
            0: c = c & 63'hFFFF;            // small values
            1: c = c | 63'h1;               // odd, the deep path
            2: c = c & 63'hFFFF_FFFF;
            default: ;
         endcase
         send_candidate(c);
      end
   endtask

   // receiver stall pattern, independent of the sender
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 7) < 2) ? 1'b0 : 1'b1;
      end
   end

   // check each result transfer against the oldest expected flag
   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_flags.size() == 0) begin
            unexpected_count++;
            if (mismatch_count + unexpected_count <= 10)
               $display("unexpected result, prime_flag=%0b", rsp_prime_flag);
         end else begin
            want = expected_flags.pop_front();
            if (rsp_prime_flag !== want) begin
               mismatch_count++;
               if (mismatch_count + unexpected_count <= 10)
                  $display("prime_flag mismatch: expected %0b actual %0b", want,
                           rsp_prime_flag);
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_candidate <= '0;
      mismatch_count = 0;
      unexpected_count = 0;
      burst_left = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_drain_pause();
      test_random();
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && unexpected_count == 0 && expected_flags.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

// ===== sim.f =====
hdl/mrpt_pkg.sv
hdl/miller_rabin_prime_test.sv
tb/sv/tb.sv
